// File: rtl/screen_fade_alpha_ramp_defines.svh
// ----------------------------------------------------------------------------
// Screen fade alpha ramp: assertion macros
// Shared property wrappers for the checker of the fade controller.
// ----------------------------------------------------------------------------
`ifndef SCREEN_FADE_ALPHA_RAMP_DEFINES_SVH
`define SCREEN_FADE_ALPHA_RAMP_DEFINES_SVH

// Clocked assertion with an explicit clock and active-low reset.
`define SFAR_ASSERT(name, clk, rst_n, prop, msg) \
  name: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);

// Clocked assertion on the default clk_i and rst_ni.
`define SFAR_ASSERT_CK(name, prop, msg) \
  `SFAR_ASSERT(name, clk_i, rst_ni, prop, msg)

`endif

// File: rtl/sfar_pkg.sv
// ----------------------------------------------------------------------------
// Screen fade alpha ramp package
// Field widths, command codes and fade status codes.
// ----------------------------------------------------------------------------
package sfar_pkg;

  localparam int unsigned COUNT_BITS_DEF = 16;
  localparam int unsigned CMD_BITS       = 2;
  localparam int unsigned DUR_BITS       = 16;
  localparam int unsigned ALPHA_BITS     = 8;
  localparam int unsigned STATUS_BITS    = 2;

  localparam logic [ALPHA_BITS-1:0] FULL_ALPHA = 8'hFF;

  localparam logic [CMD_BITS-1:0] CMD_TICK     = 2'd0;
  localparam logic [CMD_BITS-1:0] CMD_FADE_IN  = 2'd1;
  localparam logic [CMD_BITS-1:0] CMD_FADE_OUT = 2'd2;

  typedef enum logic [STATUS_BITS-1:0] {
    ST_OPAQUE   = 2'd0,
    ST_CLEAR    = 2'd1,
    ST_FADE_IN  = 2'd2,
    ST_FADE_OUT = 2'd3
  } fade_state_e;

endpackage

// File: rtl/sfar_if.sv
// ----------------------------------------------------------------------------
// Screen fade alpha ramp channels
// Valid/ready command and result channels of the fade controller.
// ----------------------------------------------------------------------------
interface sfar_cmd_if;
  import sfar_pkg::*;

  logic                valid;
  logic                ready;
  logic [CMD_BITS-1:0] cmd;
  logic [DUR_BITS-1:0] duration;

  modport source (output valid, cmd, duration, input ready);
  modport sink   (input valid, cmd, duration, output ready);
endinterface

interface sfar_res_if;
  import sfar_pkg::*;

  logic                   valid;
  logic                   ready;
  logic [ALPHA_BITS-1:0]  alpha;
  logic [STATUS_BITS-1:0] status;
  logic                   accepted;
  logic                   draw_overlay;

  modport source (output valid, alpha, status, accepted, draw_overlay, input ready);
  modport sink   (input valid, alpha, status, accepted, draw_overlay, output ready);
endinterface

// File: rtl/screen_fade_alpha_ramp.sv
// ----------------------------------------------------------------------------
// Screen fade alpha ramp
// Linear alpha fade controller for a screen overlay.
//
// cmd_i carries one command per transfer: a frame tick, a start of a fade in
// or a start of a fade out with its length in ticks. res_o returns exactly
// one result per command: overlay alpha, fade status, whether a start was
// accepted and whether the tick draws the overlay.
// A tick during a fade runs 255*count/length through one shared
// compare-subtract unit in S_DIV, one quotient bit per cycle, and S_DONE
// then loads the result into the output register. Every other command
// skips the divide and goes from S_IDLE straight to S_DONE. cmd_i.ready
// is high only while the sequencer is idle, so one command is in flight
// at a time.
// The result sits in an output register; a new command is taken while it
// waits. If res_o stalls, the next finished result holds in the sequencer
// until the register frees.
// Reset puts the fader in the opaque state with alpha 255 and no result.
// ----------------------------------------------------------------------------
module screen_fade_alpha_ramp #(
  parameter int unsigned COUNT_BITS = sfar_pkg::COUNT_BITS_DEF
) (
  input  logic      clk_i,
  input  logic      rst_ni,
  sfar_cmd_if.sink  cmd_i,
  sfar_res_if.source res_o
);
  import sfar_pkg::*;

  localparam int unsigned DIV_STEPS = ALPHA_BITS;
  localparam int unsigned ITER_BITS = $clog2(DIV_STEPS);
  localparam logic [ITER_BITS-1:0] ITER_LAST = ITER_BITS'(DIV_STEPS - 1);

  typedef enum logic [1:0] {
    S_IDLE,
    S_DIV,
    S_DONE
  } seq_state_e;

  seq_state_e                    seq_q, seq_d;
  fade_state_e                   fade_q, fade_d;
  logic [COUNT_BITS-1:0]         count_q, count_d;
  logic [COUNT_BITS-1:0]         len_q, len_d;
  logic [ALPHA_BITS-1:0]         opacity_q, opacity_d;
  logic [COUNT_BITS-1:0]         rem_q, rem_d;
  logic [ALPHA_BITS-1:0]         work_q, work_d;
  logic [ITER_BITS-1:0]          iter_q, iter_d;
  logic                          acc_q, acc_d;
  logic                          tick_q, tick_d;
  logic                          res_valid_q, res_valid_d;
  logic [ALPHA_BITS-1:0]         res_alpha_q, res_alpha_d;
  fade_state_e                   res_status_q, res_status_d;
  logic                          res_acc_q, res_acc_d;
  logic                          res_draw_q, res_draw_d;

  logic                          cmd_xfer;
  logic                          res_xfer;
  logic [COUNT_BITS-1:0]         dur_cut;
  logic [COUNT_BITS-1:0]         dur_len;
  logic [COUNT_BITS-1:0]         cnt_inc;
  logic [COUNT_BITS+ALPHA_BITS-1:0] prod;
  logic [COUNT_BITS:0]           trial;
  logic [COUNT_BITS:0]           diff;
  logic                          fits;
  logic [ALPHA_BITS-1:0]         quot;

  assign cmd_xfer = cmd_i.valid && cmd_i.ready;
  assign res_xfer = res_o.valid && res_o.ready;

  assign dur_cut = COUNT_BITS'(cmd_i.duration);
  assign dur_len = (dur_cut == '0) ? COUNT_BITS'(1) : dur_cut;
  assign cnt_inc = count_q + COUNT_BITS'(1);
  assign prod    = {cnt_inc, ALPHA_BITS'(0)}
                 - {ALPHA_BITS'(0), cnt_inc};

  assign trial = {rem_q, work_q[ALPHA_BITS-1]};
  assign fits  = trial >= {1'b0, len_q};
  assign diff  = trial - {1'b0, len_q};
  assign quot  = {work_q[ALPHA_BITS-2:0], fits};

  always_comb begin
    seq_d        = seq_q;
    fade_d       = fade_q;
    count_d      = count_q;
    len_d        = len_q;
    opacity_d    = opacity_q;
    rem_d        = rem_q;
    work_d       = work_q;
    iter_d       = iter_q;
    acc_d        = acc_q;
    tick_d       = tick_q;
    res_valid_d  = res_valid_q;
    res_alpha_d  = res_alpha_q;
    res_status_d = res_status_q;
    res_acc_d    = res_acc_q;
    res_draw_d   = res_draw_q;

    if (res_xfer) begin
      res_valid_d = 1'b0;
    end

    unique case (seq_q)
      S_IDLE: begin
        if (cmd_xfer) begin
          acc_d  = 1'b0;
          tick_d = 1'b0;
          seq_d  = S_DONE;
          case (cmd_i.cmd)
            CMD_TICK: begin
              if (fade_q != ST_CLEAR) begin
                tick_d = 1'b1;
                if (fade_q == ST_OPAQUE) begin
                  opacity_d = FULL_ALPHA;
                end else begin
                  count_d = cnt_inc;
                  rem_d   = prod[COUNT_BITS+ALPHA_BITS-1:ALPHA_BITS];
                  work_d  = prod[ALPHA_BITS-1:0];
                  iter_d  = '0;
                  seq_d   = S_DIV;
                end
              end
            end
            CMD_FADE_IN: begin
              if (fade_q == ST_OPAQUE) begin
                fade_d  = ST_FADE_IN;
                count_d = '0;
                len_d   = dur_len;
                acc_d   = 1'b1;
              end
            end
            CMD_FADE_OUT: begin
              if (fade_q == ST_CLEAR) begin
                fade_d  = ST_FADE_OUT;
                count_d = '0;
                len_d   = dur_len;
                acc_d   = 1'b1;
              end
            end
            default: ;
          endcase
        end
      end
      S_DIV: begin
        rem_d  = fits ? diff[COUNT_BITS-1:0] : trial[COUNT_BITS-1:0];
        work_d = quot;
        iter_d = iter_q + ITER_BITS'(1);
        if (iter_q == ITER_LAST) begin
          seq_d = S_DONE;
          if (fade_q == ST_FADE_IN) begin
            opacity_d = FULL_ALPHA - quot;
            if (count_q >= len_q) begin
              fade_d = ST_CLEAR;
            end
          end else begin
            opacity_d = quot;
            if (count_q >= len_q) begin
              fade_d = ST_OPAQUE;
            end
          end
        end
      end
      S_DONE: begin
        if (!res_valid_q || res_o.ready) begin
          res_valid_d  = 1'b1;
          res_alpha_d  = opacity_q;
          res_status_d = fade_q;
          res_acc_d    = acc_q;
          res_draw_d   = tick_q && (opacity_q != '0);
          seq_d        = S_IDLE;
        end
      end
      default: seq_d = S_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      seq_q        <= S_IDLE;
      fade_q       <= ST_OPAQUE;
      count_q      <= '0;
      len_q        <= '0;
      opacity_q    <= FULL_ALPHA;
      rem_q        <= '0;
      work_q       <= '0;
      iter_q       <= '0;
      acc_q        <= 1'b0;
      tick_q       <= 1'b0;
      res_valid_q  <= 1'b0;
      res_alpha_q  <= '0;
      res_status_q <= ST_OPAQUE;
      res_acc_q    <= 1'b0;
      res_draw_q   <= 1'b0;
    end else begin
      seq_q        <= seq_d;
      fade_q       <= fade_d;
      count_q      <= count_d;
      len_q        <= len_d;
      opacity_q    <= opacity_d;
      rem_q        <= rem_d;
      work_q       <= work_d;
      iter_q       <= iter_d;
      acc_q        <= acc_d;
      tick_q       <= tick_d;
      res_valid_q  <= res_valid_d;
      res_alpha_q  <= res_alpha_d;
      res_status_q <= res_status_d;
      res_acc_q    <= res_acc_d;
      res_draw_q   <= res_draw_d;
    end
  end

  assign cmd_i.ready        = (seq_q == S_IDLE);
  assign res_o.valid        = res_valid_q;
  assign res_o.alpha        = res_alpha_q;
  assign res_o.status       = res_status_q;
  assign res_o.accepted     = res_acc_q;
  assign res_o.draw_overlay = res_draw_q;

endmodule

// File: rtl/sfar_checker.sv
// ----------------------------------------------------------------------------
// Screen fade alpha ramp checker
// Port-level properties of the fade controller, bound to the top level.
// ----------------------------------------------------------------------------
`include "screen_fade_alpha_ramp_defines.svh"

module sfar_checker (
  input logic                             clk_i,
  input logic                             rst_ni,
  input logic                             cmd_valid_i,
  input logic                             cmd_ready_i,
  input logic                             res_valid_i,
  input logic                             res_ready_i,
  input logic [sfar_pkg::ALPHA_BITS-1:0]  res_alpha_i,
  input logic [sfar_pkg::STATUS_BITS-1:0] res_status_i,
  input logic                             res_accepted_i,
  input logic                             res_draw_i
);
  import sfar_pkg::*;

  `SFAR_ASSERT_CK(a_res_hold, res_valid_i && !res_ready_i |=> res_valid_i, "result dropped while stalled")

  `SFAR_ASSERT_CK(a_busy_after_xfer, cmd_valid_i && cmd_ready_i |=> !cmd_ready_i, "command taken while busy")

  `SFAR_ASSERT_CK(a_accept_fading, res_valid_i && res_accepted_i |-> !res_draw_i && (res_status_i == ST_FADE_IN || res_status_i == ST_FADE_OUT), "accepted start not fading")

  `SFAR_ASSERT_CK(a_clear_alpha, res_valid_i && res_status_i == ST_CLEAR |-> res_alpha_i == '0 && !res_draw_i, "clear state with nonzero alpha")

  `SFAR_ASSERT_CK(a_opaque_alpha, res_valid_i && res_status_i == ST_OPAQUE |-> res_alpha_i == FULL_ALPHA, "opaque state without full alpha")

endmodule

bind screen_fade_alpha_ramp sfar_checker u_sfar_checker (
  .clk_i          (clk_i),
  .rst_ni         (rst_ni),
  .cmd_valid_i    (cmd_i.valid),
  .cmd_ready_i    (cmd_i.ready),
  .res_valid_i    (res_o.valid),
  .res_ready_i    (res_o.ready),
  .res_alpha_i    (res_o.alpha),
  .res_status_i   (res_o.status),
  .res_accepted_i (res_o.accepted),
  .res_draw_i     (res_o.draw_overlay)
);

// File: tb/testbench.sv
// ----------------------------------------------------------------------------
// Screen fade alpha ramp testbench
// Sends frame ticks, fade starts and unused codes over the command channel:
// a directed opening and then complete fade sequences with random lengths
// and noise. Random idle bursts fall on both channels. Every result is
// compared field by field against an in-order prediction.
// ----------------------------------------------------------------------------
module testbench;
  import sfar_pkg::*;

  localparam logic [CMD_BITS-1:0] CMD_UNUSED = 2'd3;
  localparam int unsigned RANDOM_ITEMS = 1050;
  localparam int unsigned CALM_TAIL    = 120;
  localparam int unsigned MAX_REPORTS  = 10;
  localparam int unsigned DRAIN_CYCLES = 30;

  typedef struct packed {
    logic [CMD_BITS-1:0] cmd;
    logic [DUR_BITS-1:0] duration;
  } fade_cmd_t;

  typedef struct packed {
    logic [ALPHA_BITS-1:0]  alpha;
    logic [STATUS_BITS-1:0] status;
    logic                   accepted;
    logic                   draw_overlay;
  } fade_res_t;

  logic clk_i;
  logic rst_ni;

  sfar_cmd_if cmd_bus ();
  sfar_res_if res_bus ();

  screen_fade_alpha_ramp dut (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .cmd_i  (cmd_bus),
    .res_o  (res_bus)
  );

  fade_cmd_t   cmd_backlog[$];
  fade_res_t   expected_results[$];
  int unsigned total_cmds;
  int unsigned sent_cmds;
  int unsigned seen_results;
  int unsigned mismatches;
  int unsigned send_gap;
  int unsigned recv_gap;
  int unsigned send_mode;
  int unsigned recv_mode;
  bit          cmd_done;
  bit          gen_clear;

  fade_state_e           ramp_state;
  logic [DUR_BITS-1:0]   ramp_count;
  logic [DUR_BITS-1:0]   ramp_length;
  logic [ALPHA_BITS-1:0] ramp_alpha;

  function automatic logic [ALPHA_BITS-1:0] ramp_level(input logic [DUR_BITS-1:0] count,
                                                      input logic [DUR_BITS-1:0] length);
    logic [31:0] q;
    q = (32'(count) * 32'(FULL_ALPHA)) / ((length == '0) ? 32'd1 : 32'(length));
    return (q > 32'(FULL_ALPHA)) ? FULL_ALPHA : q[ALPHA_BITS-1:0];
  endfunction

  function automatic fade_res_t fade_step(input fade_cmd_t c);
    fade_res_t             r;
    logic [ALPHA_BITS-1:0] level;
    logic [DUR_BITS-1:0]   len;
    r.accepted     = 1'b0;
    r.draw_overlay = 1'b0;
    len = (c.duration == '0) ? DUR_BITS'(1) : c.duration;
    case (c.cmd)
      CMD_TICK: begin
        if (ramp_state != ST_CLEAR) begin
          if (ramp_state == ST_OPAQUE) begin
            ramp_alpha = FULL_ALPHA;
          end else begin
            ramp_count = ramp_count + DUR_BITS'(1);
            level = ramp_level(ramp_count, ramp_length);
            if (ramp_state == ST_FADE_IN) begin
              ramp_alpha = FULL_ALPHA - level;
              if (ramp_count >= ramp_length) ramp_state = ST_CLEAR;
            end else begin
              ramp_alpha = level;
              if (ramp_count >= ramp_length) ramp_state = ST_OPAQUE;
            end
          end
          r.draw_overlay = (ramp_alpha != '0);
        end
      end
      CMD_FADE_IN: begin
        if (ramp_state == ST_OPAQUE) begin
          ramp_state  = ST_FADE_IN;
          ramp_count  = '0;
          ramp_length = len;
          r.accepted  = 1'b1;
        end
      end
      CMD_FADE_OUT: begin
        if (ramp_state == ST_CLEAR) begin
          ramp_state  = ST_FADE_OUT;
          ramp_count  = '0;
          ramp_length = len;
          r.accepted  = 1'b1;
        end
      end
      default: begin
      end
    endcase
    r.alpha  = ramp_alpha;
    r.status = ramp_state;
    return r;
  endfunction

  task automatic queue_cmd(input logic [CMD_BITS-1:0] c, input logic [DUR_BITS-1:0] d);
    fade_cmd_t item;
    item.cmd      = c;
    item.duration = d;
    cmd_backlog.push_back(item);
  endtask

  task automatic queue_noise(input bit fading);
    logic [DUR_BITS-1:0] d;
    d = DUR_BITS'($urandom_range(0, 16'hFFFF));
    case ($urandom_range(0, 2))
      0: queue_cmd(CMD_UNUSED, d);
      1: begin
        if (fading) queue_cmd($urandom_range(0, 1) ? CMD_FADE_IN : CMD_FADE_OUT, d);
        else queue_cmd(gen_clear ? CMD_FADE_IN : CMD_FADE_OUT, d);
      end
      default: queue_cmd(fading ? CMD_UNUSED : CMD_TICK, d);
    endcase
  endtask

  initial begin
    clk_i = 1'b0;
  end

  always begin
    #5 clk_i = ~clk_i;
  end

  initial begin
    #5_000_000;
    $display("CHECK FAILED");
    $finish;
  end

  initial begin : stimulus
    logic [DUR_BITS-1:0] dur;
    int unsigned         len;
    rst_ni           = 1'b0;
    cmd_bus.valid    = 1'b0;
    cmd_bus.cmd      = CMD_TICK;
    cmd_bus.duration = '0;
    res_bus.ready    = 1'b0;
    ramp_state       = ST_OPAQUE;
    ramp_count       = '0;
    ramp_length      = '0;
    ramp_alpha       = FULL_ALPHA;
    sent_cmds        = 0;
    seen_results     = 0;
    mismatches       = 0;
    send_gap         = 0;
    recv_gap         = 0;
    send_mode        = 1;
    recv_mode        = 1;
    cmd_done         = 1'b0;
    gen_clear        = 1'b0;

    queue_cmd(CMD_TICK, 16'hFFFF);
    queue_cmd(CMD_UNUSED, 16'hAAAA);
    queue_cmd(CMD_FADE_OUT, 16'd5);
    queue_cmd(CMD_FADE_IN, 16'd0);
    queue_cmd(CMD_FADE_IN, 16'd3);
    queue_cmd(CMD_FADE_OUT, 16'd3);
    queue_cmd(CMD_UNUSED, 16'h5555);
    queue_cmd(CMD_TICK, 16'h8000);
    queue_cmd(CMD_TICK, 16'h7FFF);
    queue_cmd(CMD_FADE_IN, 16'd7);
    queue_cmd(CMD_UNUSED, 16'd0);
    queue_cmd(CMD_FADE_OUT, 16'd0);
    queue_cmd(CMD_TICK, 16'd0);
    queue_cmd(CMD_FADE_IN, 16'd2);
    repeat (2) queue_cmd(CMD_TICK, 16'd1);
    queue_cmd(CMD_FADE_OUT, 16'd3);
    repeat (3) queue_cmd(CMD_TICK, 16'hFFFF);

    while (cmd_backlog.size() < RANDOM_ITEMS) begin
      repeat ($urandom_range(0, 2)) queue_noise(1'b0);
      case ($urandom_range(0, 15))
        0:                dur = '0;
        1, 2, 3, 4, 5, 6,
        7, 8, 9, 10, 11:  dur = DUR_BITS'($urandom_range(1, 8));
        12, 13, 14:       dur = DUR_BITS'($urandom_range(9, 40));
        default:          dur = DUR_BITS'($urandom_range(41, 300));
      endcase
      queue_cmd(gen_clear ? CMD_FADE_OUT : CMD_FADE_IN, dur);
      len = (dur == '0) ? 1 : int'(dur);
      repeat (len) begin
        queue_cmd(CMD_TICK, DUR_BITS'($urandom_range(0, 16'hFFFF)));
        if ($urandom_range(0, 5) == 0) queue_noise(1'b1);
      end
      gen_clear = !gen_clear;
    end

    if (gen_clear) begin
      queue_cmd(CMD_FADE_OUT, 16'd1);
      queue_cmd(CMD_TICK, 16'd0);
    end
    queue_cmd(CMD_FADE_IN, 16'hFFFF);
    repeat (6) queue_cmd(CMD_TICK, DUR_BITS'($urandom_range(0, 16'hFFFF)));
    queue_cmd(CMD_UNUSED, 16'hFFFF);
    total_cmds = cmd_backlog.size();

    repeat (4) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni = 1'b1;

    wait (cmd_backlog.size() == 0 && sent_cmds == total_cmds);
    wait (expected_results.size() == 0);
    repeat (DRAIN_CYCLES) @(posedge clk_i);
    if (mismatches == 0 && expected_results.size() == 0) begin
      $display("CHECK OK");
    end else begin
      $display("CHECK FAILED");
    end
    $finish;
  end

  always @(posedge clk_i) begin : monitor
    fade_res_t got;
    fade_res_t want;
    fade_cmd_t taken;
    if (rst_ni) begin
      if (res_bus.valid && res_bus.ready) begin
        seen_results++;
        got.alpha        = res_bus.alpha;
        got.status       = res_bus.status;
        got.accepted     = res_bus.accepted;
        got.draw_overlay = res_bus.draw_overlay;
        if (expected_results.size() == 0) begin
          mismatches++;
          if (mismatches <= MAX_REPORTS) begin
            $display("unexpected result: alpha %0d status %0d accepted %0b draw %0b",
                     got.alpha, got.status, got.accepted, got.draw_overlay);
          end
        end else begin
          want = expected_results.pop_front();
          if (got.alpha !== want.alpha || got.status !== want.status ||
              got.accepted !== want.accepted || got.draw_overlay !== want.draw_overlay) begin
            mismatches++;
            if (mismatches <= MAX_REPORTS) begin
              $display("result %0d: alpha %0d/%0d status %0d/%0d accepted %0b/%0b draw %0b/%0b",
                       seen_results, got.alpha, want.alpha, got.status, want.status,
                       got.accepted, want.accepted, got.draw_overlay, want.draw_overlay);
            end
          end
        end
      end
      if (cmd_bus.valid && cmd_bus.ready) begin
        taken.cmd      = cmd_bus.cmd;
        taken.duration = cmd_bus.duration;
        expected_results.push_back(fade_step(taken));
        sent_cmds++;
        cmd_done = 1'b1;
      end
    end
  end

  always @(negedge clk_i) begin : cmd_driver
    fade_cmd_t item;
    if (rst_ni) begin
      if (!cmd_bus.valid || cmd_done) begin
        if (cmd_bus.valid && sent_cmds % 64 == 0) send_mode = $urandom_range(0, 2);
        if (cmd_bus.valid && sent_cmds + CALM_TAIL < total_cmds && send_mode != 0 &&
            $urandom_range(0, (send_mode == 1) ? 7 : 2) == 0) begin
          send_gap = $urandom_range(1, 18);
        end
        cmd_done = 1'b0;
        if (send_gap != 0) begin
          send_gap--;
          cmd_bus.valid <= 1'b0;
        end else if (cmd_backlog.size() != 0) begin
          item = cmd_backlog.pop_front();
          cmd_bus.valid    <= 1'b1;
          cmd_bus.cmd      <= item.cmd;
          cmd_bus.duration <= item.duration;
        end else begin
          cmd_bus.valid <= 1'b0;
        end
      end
    end
  end

  always @(negedge clk_i) begin : res_driver
    if (rst_ni) begin
      if (recv_gap != 0) begin
        recv_gap--;
        res_bus.ready <= 1'b0;
      end else if (seen_results + CALM_TAIL < total_cmds && recv_mode != 0 &&
                   $urandom_range(0, (recv_mode == 1) ? 15 : 4) == 0) begin
        recv_gap = $urandom_range(1, 18) - 1;
        res_bus.ready <= 1'b0;
      end else begin
        res_bus.ready <= 1'b1;
      end
      if ($urandom_range(0, 99) == 0) recv_mode = $urandom_range(0, 2);
    end
  end

endmodule
